// ===== design/tgst_pkg.sv =====
`timescale 1ns / 1ps

package tgst_pkg;

  localparam int TIME_BITS   = 32;
  localparam int SAMPLE_BITS = 10;
  localparam int LEVEL_STEP  = 'h66;
  localparam int LEVEL_MAX   = 9;
  localparam int LEVEL_W     = 4;
  localparam int CFG_W       = 16;
  localparam int SPEED_W     = 16;
  localparam int PROD_W      = 2 * CFG_W;
  localparam int CNT_W       = $clog2(PROD_W);
  localparam int STEP_W      = 3;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 4'd4;
  localparam logic [CFG_W-1:0]   DISTANCE_RESET  = 16'd125;
  localparam logic [CFG_W-1:0]   RATE_RESET      = 16'd250;
  localparam logic [SPEED_W-1:0] SPEED_MAX       = '1;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [STEP_W-1:0]  step_t;

  localparam step_t STEP_WAIT = 3'd0;
  localparam step_t STEP_GATE = 3'd1;
  localparam step_t STEP_MUL  = 3'd2;
  localparam step_t STEP_DIV  = 3'd3;
  localparam step_t STEP_EMIT = 3'd4;
  localparam step_t STEP_LAST = STEP_EMIT;

  typedef enum logic [1:0] {
    CFG_LEVEL_THRESHOLD = 2'd0,
    CFG_GATE_DISTANCE   = 2'd1,
    CFG_TICK_RATE       = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    GS_IDLE  = 2'd0,
    GS_TRIG  = 2'd1,
    GS_LATCH = 2'd2
  } gate_stage_t;

  typedef enum logic [2:0] {
    JC_NONE     = 3'd0,
    JC_NO_INPUT = 3'd1,
    JC_NO_FIRE  = 3'd2,
    JC_ZERO     = 3'd3,
    JC_DIV_MORE = 3'd4,
    JC_OUT_BUSY = 3'd5
  } jump_cond_t;

  typedef struct packed {
    logic       accept;
    logic       gate;
    logic       mul;
    logic       div_step;
    logic       emit;
    jump_cond_t cond;
    step_t      target;
  } ctrl_word_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] entry_sample;
    logic [SAMPLE_BITS-1:0] exit_sample;
    logic [TIME_BITS-1:0]   time_now;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_value;
    logic [7:0]         exit_time_byte;
    logic               zero_interval;
  } out_item_t;

  function automatic level_t quantize(logic [SAMPLE_BITS-1:0] s);
    level_t lv;
    lv = '0;
    for (int k = 1; k <= LEVEL_MAX; k++) begin
      if (s > SAMPLE_BITS'(k * LEVEL_STEP)) begin
        lv = lv + level_t'(1);
      end
    end
    return lv;
  endfunction

  function automatic ctrl_word_t ucode_rom(step_t pc);
    ctrl_word_t cw;
    cw = '{accept: 1'b0, gate: 1'b0, mul: 1'b0, div_step: 1'b0, emit: 1'b0,
           cond: JC_NONE, target: STEP_WAIT};
    unique case (pc)
      STEP_WAIT: begin
        cw.accept = 1'b1;
        cw.cond   = JC_NO_INPUT;
        cw.target = STEP_WAIT;
      end
      STEP_GATE: begin
        cw.gate   = 1'b1;
        cw.cond   = JC_NO_FIRE;
        cw.target = STEP_WAIT;
      end
      STEP_MUL: begin
        cw.mul    = 1'b1;
        cw.cond   = JC_ZERO;
        cw.target = STEP_EMIT;
      end
      STEP_DIV: begin
        cw.div_step = 1'b1;
        cw.cond     = JC_DIV_MORE;
        cw.target   = STEP_DIV;
      end
      STEP_EMIT: begin
        cw.emit   = 1'b1;
        cw.cond   = JC_OUT_BUSY;
        cw.target = STEP_EMIT;
      end
      default: begin
        cw.target = STEP_WAIT;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== design/two_gate_speed_timer_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_stall   in_data (in_item_t)
// out       output     out_valid/out_stall out_data (out_item_t)
// cfg       input      cfg_we              cfg_index, cfg_data
//
// A scan that gives a speed passes through accept, gate update, multiply,
// 32 divider steps of one quotient bit each, and emit; one that gives no
// speed ends after the gate update. A zero interval skips the divider.
// Synchronous active-low reset restores the register defaults and idles both gates.
// A result waits in the output register while the next item is accepted; the
// emit step holds only while a previous result is still stalled.

module two_gate_speed_timer_core
  import tgst_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  step_t                  pc_r, pc_nxt;
  level_t                 thr_r, thr_nxt;
  logic [CFG_W-1:0]       dist_r, dist_nxt;
  logic [CFG_W-1:0]       rate_r, rate_nxt;
  gate_stage_t            entry_stage_r, entry_stage_nxt;
  gate_stage_t            exit_stage_r, exit_stage_nxt;
  logic                   armed_r, armed_nxt;
  logic [TIME_BITS-1:0]   entry_time_r, entry_time_nxt;
  in_item_t               item_r, item_nxt;
  logic                   zero_r, zero_nxt;
  logic [TIME_BITS-1:0]   div_r, div_nxt;
  logic [TIME_BITS-1:0]   rem_r, rem_nxt;
  logic [PROD_W-1:0]      quo_r, quo_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_data_r, out_data_nxt;

  ctrl_word_t             cw;
  logic                   take;
  logic                   out_busy;
  logic                   jump;
  logic                   blk_in, blk_out;
  gate_stage_t            es, xs;
  logic                   arm_g;
  logic [TIME_BITS-1:0]   etime_g;
  logic                   fire;
  logic [TIME_BITS-1:0]   elapsed;
  logic [TIME_BITS:0]     rem_sh;
  logic                   ge;

  assign cw       = ucode_rom(pc_r);
  assign in_stall = ~cw.accept;
  assign take     = in_valid & cw.accept;
  assign out_busy = out_valid_r & out_stall;

  always_comb begin
    blk_in  = quantize(item_r.entry_sample) >= thr_r;
    blk_out = quantize(item_r.exit_sample) >= thr_r;
    es      = entry_stage_r;
    xs      = exit_stage_r;
    arm_g   = armed_r;
    etime_g = entry_time_r;
    fire    = 1'b0;
    if (blk_in && es == GS_IDLE) begin
      es = GS_TRIG;
    end
    if (blk_out && xs == GS_IDLE) begin
      xs = GS_TRIG;
    end
    if (!blk_out && xs == GS_LATCH) begin
      es = GS_IDLE;
      xs = GS_IDLE;
    end
    if (es == GS_TRIG) begin
      es      = GS_LATCH;
      etime_g = item_r.time_now;
      arm_g   = 1'b1;
    end
    if (xs == GS_TRIG) begin
      xs = GS_LATCH;
      if (arm_g) begin
        fire  = 1'b1;
        arm_g = 1'b0;
      end
    end
    elapsed = item_r.time_now - etime_g;
  end

  always_comb begin
    rem_sh = {rem_r, quo_r[PROD_W-1]};
    ge     = rem_sh >= {1'b0, div_r};
  end

  always_comb begin
    unique case (cw.cond)
      JC_NONE:     jump = 1'b0;
      JC_NO_INPUT: jump = ~in_valid;
      JC_NO_FIRE:  jump = ~fire;
      JC_ZERO:     jump = zero_r;
      JC_DIV_MORE: jump = cnt_r != '1;
      JC_OUT_BUSY: jump = out_busy;
      default:     jump = 1'b0;
    endcase
    if (jump) begin
      pc_nxt = cw.target;
    end else if (pc_r == STEP_LAST) begin
      pc_nxt = STEP_WAIT;
    end else begin
      pc_nxt = pc_r + step_t'(1);
    end
  end

  always_comb begin
    thr_nxt         = thr_r;
    dist_nxt        = dist_r;
    rate_nxt        = rate_r;
    entry_stage_nxt = entry_stage_r;
    exit_stage_nxt  = exit_stage_r;
    armed_nxt       = armed_r;
    entry_time_nxt  = entry_time_r;
    item_nxt        = item_r;
    zero_nxt        = zero_r;
    div_nxt         = div_r;
    rem_nxt         = rem_r;
    quo_nxt         = quo_r;
    cnt_nxt         = cnt_r;
    out_valid_nxt   = out_busy;
    out_data_nxt    = out_data_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LEVEL_THRESHOLD: thr_nxt  = cfg_data[LEVEL_W-1:0];
        CFG_GATE_DISTANCE:   dist_nxt = cfg_data;
        CFG_TICK_RATE:       rate_nxt = cfg_data;
        default:             ;
      endcase
    end

    if (take) begin
      item_nxt = in_data;
    end

    if (cw.gate) begin
      entry_stage_nxt = es;
      exit_stage_nxt  = xs;
      armed_nxt       = arm_g;
      entry_time_nxt  = etime_g;
      zero_nxt        = elapsed == '0;
      div_nxt         = elapsed;
    end

    if (cw.mul) begin
      quo_nxt = PROD_W'(dist_r) * PROD_W'(rate_r);
      rem_nxt = '0;
      cnt_nxt = '0;
    end

    if (cw.div_step) begin
      rem_nxt = ge ? TIME_BITS'(rem_sh - {1'b0, div_r}) : rem_sh[TIME_BITS-1:0];
      quo_nxt = {quo_r[PROD_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
    end

    if (cw.emit && !out_busy) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.exit_time_byte = item_r.time_now[15:8];
      out_data_nxt.zero_interval  = zero_r;
      if (zero_r || quo_r[PROD_W-1:SPEED_W] != '0) begin
        out_data_nxt.speed_value = SPEED_MAX;
      end else begin
        out_data_nxt.speed_value = quo_r[SPEED_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r          <= STEP_WAIT;
      thr_r         <= THRESHOLD_RESET;
      dist_r        <= DISTANCE_RESET;
      rate_r        <= RATE_RESET;
      entry_stage_r <= GS_IDLE;
      exit_stage_r  <= GS_IDLE;
      armed_r       <= 1'b0;
      entry_time_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      pc_r          <= pc_nxt;
      thr_r         <= thr_nxt;
      dist_r        <= dist_nxt;
      rate_r        <= rate_nxt;
      entry_stage_r <= entry_stage_nxt;
      exit_stage_r  <= exit_stage_nxt;
      armed_r       <= armed_nxt;
      entry_time_r  <= entry_time_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    zero_r     <= zero_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_zero_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.zero_interval |-> out_data_r.speed_value == SPEED_MAX)
    else $error("zero interval without saturated speed");

  a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == STEP_EMIT && $past(pc_r) == STEP_DIV |-> $past(cnt_r) == '1)
    else $error("divider left before all quotient bits were formed");

  a_no_trig_rest: assert property (@(posedge clk) disable iff (!rst_n)
    entry_stage_r != GS_TRIG && exit_stage_r != GS_TRIG)
    else $error("gate left in triggered stage between items");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import tgst_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  two_gate_speed_timer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_item_t  scan_queue[$];
  out_item_t speed_expect[$];
  out_item_t predicted_speed;
  out_item_t oldest_speed;
  int        error_count = 0;
  int        queued_count = 0;
  int        in_idle_pct = 22;
  int        out_idle_pct = 22;
  bit        hold_req = 1'b0;
  int        hold_left = 0;
  int        gap_mode = 1;
  logic [31:0] t_now = '0;

  level_t           thr_cfg  = THRESHOLD_RESET;
  logic [CFG_W-1:0] dist_cfg = DISTANCE_RESET;
  logic [CFG_W-1:0] rate_cfg = RATE_RESET;

  gate_stage_t entry_st = GS_IDLE;
  gate_stage_t exit_st  = GS_IDLE;
  bit          armed_q  = 1'b0;
  logic [31:0] entry_capture = '0;

  function automatic int scan_level(logic [SAMPLE_BITS-1:0] s);
    int lv;
    if (s == 0) begin
      return 0;
    end
    lv = (int'(s) - 1) / 'h66;
    return (lv > 9) ? 9 : lv;
  endfunction

  function automatic bit advance_gates(input in_item_t scan, output out_item_t res);
    int          lv_entry;
    int          lv_exit;
    logic [31:0] elapsed;
    logic [31:0] prod;
    logic [31:0] quot;
    bit          fired;
    lv_entry = scan_level(scan.entry_sample);
    lv_exit  = scan_level(scan.exit_sample);
    fired    = 1'b0;
    res      = '0;
    if (lv_entry >= int'(thr_cfg) && entry_st == GS_IDLE) begin
      entry_st = GS_TRIG;
    end
    if (lv_exit >= int'(thr_cfg) && exit_st == GS_IDLE) begin
      exit_st = GS_TRIG;
    end
    if (lv_exit < int'(thr_cfg) && exit_st == GS_LATCH) begin
      entry_st = GS_IDLE;
      exit_st  = GS_IDLE;
    end
    if (entry_st == GS_TRIG) begin
      entry_capture = scan.time_now;
      entry_st      = GS_LATCH;
      armed_q       = 1'b1;
    end
    if (exit_st == GS_TRIG) begin
      exit_st = GS_LATCH;
      if (armed_q) begin
        elapsed = scan.time_now - entry_capture;
        prod    = 32'(dist_cfg) * 32'(rate_cfg);
        res.exit_time_byte = scan.time_now[15:8];
        if (elapsed == 0) begin
          res.speed_value   = SPEED_MAX;
          res.zero_interval = 1'b1;
        end else begin
          quot = prod / elapsed;
          res.speed_value   = (quot > 32'hFFFF) ? SPEED_MAX : quot[15:0];
          res.zero_interval = 1'b0;
        end
        armed_q = 1'b0;
        fired   = 1'b1;
      end
    end
    return fired;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (advance_gates(in_data, predicted_speed)) begin
          speed_expect.push_back(predicted_speed);
        end
      end
      if (!in_valid || !in_stall) begin
        if (scan_queue.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
          in_data  <= scan_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (speed_expect.size() == 0) begin
          $display("%0t: result with none expected, actual %h", $time, out_data);
          error_count++;
        end else begin
          oldest_speed = speed_expect.pop_front();
          if (out_data.speed_value !== oldest_speed.speed_value) begin
            $display("%0t: speed_value expected %h actual %h", $time,
                     oldest_speed.speed_value, out_data.speed_value);
            error_count++;
          end
          if (out_data.exit_time_byte !== oldest_speed.exit_time_byte) begin
            $display("%0t: exit_time_byte expected %h actual %h", $time,
                     oldest_speed.exit_time_byte, out_data.exit_time_byte);
            error_count++;
          end
          if (out_data.zero_interval !== oldest_speed.zero_interval) begin
            $display("%0t: zero_interval expected %h actual %h", $time,
                     oldest_speed.zero_interval, out_data.zero_interval);
            error_count++;
          end
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < out_idle_pct);
      end
    end
  end

  function automatic logic [9:0] sample_at(int lv);
    int lo;
    int hi;
    if (lv == 0) begin
      return 10'($urandom_range(0, 'h66));
    end
    lo = lv * 'h66 + 1;
    hi = (lv == 9) ? 'h3FF : lv * 'h66 + 'h66;
    return 10'($urandom_range(lo, hi));
  endfunction

  function automatic logic [9:0] blocked_sample();
    if (thr_cfg > 9) begin
      return 10'($urandom_range(0, 1023));
    end
    return sample_at($urandom_range(thr_cfg, 9));
  endfunction

  function automatic logic [9:0] clear_sample();
    if (thr_cfg == 0) begin
      return sample_at($urandom_range(0, 9));
    end
    return sample_at($urandom_range(0, (thr_cfg > 9) ? 9 : thr_cfg - 1));
  endfunction

  function automatic logic [31:0] next_gap();
    case (gap_mode)
      0: return 32'd0;
      1, 2, 3, 4: return $urandom_range(1, 50);
      5, 6, 7: return $urandom_range(51, 5000);
      8: return $urandom_range(5001, 1000000);
      default: return $urandom;
    endcase
  endfunction

  task automatic push_scan(input logic [9:0] e, input logic [9:0] x, input logic [31:0] t);
    scan_queue.push_back('{entry_sample: e, exit_sample: x, time_now: t});
    queued_count++;
  endtask

  task automatic scan_step(input logic [9:0] e, input logic [9:0] x);
    push_scan(e, x, t_now);
    t_now = t_now + next_gap();
  endtask

  task automatic add_pass();
    gap_mode = $urandom_range(0, 9);
    if ($urandom_range(0, 9) == 0) begin
      t_now = 32'hFFFF_FFFF - $urandom_range(0, 2000);
    end
    repeat ($urandom_range(0, 2)) scan_step(clear_sample(), clear_sample());
    if ($urandom_range(0, 7) == 0) begin
      scan_step(blocked_sample(), blocked_sample());
    end else begin
      repeat ($urandom_range(1, 3)) scan_step(blocked_sample(), clear_sample());
      repeat ($urandom_range(0, 3)) begin
        scan_step($urandom_range(0, 1) ? blocked_sample() : clear_sample(), clear_sample());
      end
    end
    repeat ($urandom_range(1, 3)) begin
      scan_step($urandom_range(0, 1) ? blocked_sample() : clear_sample(), blocked_sample());
    end
    repeat ($urandom_range(1, 2)) scan_step(clear_sample(), clear_sample());
  endtask

  task automatic random_scans(input int n);
    int target;
    target = queued_count + n;
    while (queued_count < target) begin
      if ($urandom_range(0, 99) < 80) begin
        add_pass();
      end else if ($urandom_range(0, 1) == 0) begin
        scan_step(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)));
      end else begin
        push_scan(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)), $urandom);
      end
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_LEVEL_THRESHOLD: thr_cfg = val[LEVEL_W-1:0];
      CFG_GATE_DISTANCE:   dist_cfg = val;
      CFG_TICK_RATE:       rate_cfg = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (scan_queue.size() != 0 || in_valid || speed_expect.size() != 0) begin
      @(negedge clk);
    end
    repeat (40) @(negedge clk);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_LEVEL_THRESHOLD;
    cfg_data  = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_scan(10'h000, 10'h000, 32'h0000_0100);
    push_scan(10'h198, 10'h000, 32'h0000_0110);
    push_scan(10'h000, 10'h3FF, 32'h0000_0120);
    push_scan(10'h3FF, 10'h3FF, 32'h0000_0130);
    push_scan(10'h3FC, 10'h000, 32'h0000_0140);
    push_scan(10'h199, 10'h000, 32'h0000_1234);
    push_scan(10'h000, 10'h199, 32'h0000_123B);
    push_scan(10'h000, 10'h000, 32'h0000_1300);
    push_scan(10'h3FD, 10'h3FE, 32'h00AB_CD00);
    push_scan(10'h000, 10'h000, 32'h00AB_CE00);
    push_scan(10'h3FF, 10'h000, 32'hFFFF_FFFE);
    push_scan(10'h200, 10'h000, 32'hFFFF_FFFF);
    push_scan(10'h000, 10'h3FF, 32'h0000_0003);
    push_scan(10'h000, 10'h3FF, 32'h0000_0010);
    push_scan(10'h3FF, 10'h066, 32'h0000_0020);
    push_scan(10'h3FF, 10'h000, 32'h0000_0030);
    push_scan(10'h000, 10'h3FF, 32'h0000_0030 + 32'd31251);
    push_scan(10'h000, 10'h000, 32'h0000_0000);
    drain();

    write_reg(CFG_LEVEL_THRESHOLD, 16'd0);
    write_reg(CFG_GATE_DISTANCE, 16'hFFFF);
    write_reg(CFG_TICK_RATE, 16'hFFFF);
    @(negedge clk);
    push_scan(10'h000, 10'h000, 32'hFFFF_FFF0);
    random_scans(20);
    drain();

    write_reg(CFG_LEVEL_THRESHOLD, 16'd9);
    @(negedge clk);
    push_scan(10'h3FF, 10'h000, 32'hFFFF_FFF0);
    push_scan(10'h000, 10'h397, 32'h0000_0010);
    push_scan(10'h396, 10'h396, 32'h0000_0020);
    random_scans(100);
    drain();

    write_reg(CFG_LEVEL_THRESHOLD, 16'd15);
    write_reg(CFG_GATE_DISTANCE, 16'd1);
    write_reg(CFG_TICK_RATE, 16'd1);
    @(negedge clk);
    random_scans(30);
    drain();

    write_reg(CFG_LEVEL_THRESHOLD, 16'd3);
    write_reg(CFG_GATE_DISTANCE, 16'd0);
    write_reg(CFG_TICK_RATE, 16'd500);
    @(negedge clk);
    random_scans(60);
    drain();

    write_reg(CFG_LEVEL_THRESHOLD, 16'd5);
    write_reg(CFG_GATE_DISTANCE, 16'd1000);
    write_reg(CFG_TICK_RATE, 16'd0);
    @(negedge clk);
    random_scans(60);
    drain();

    write_reg(CFG_LEVEL_THRESHOLD, 16'd2);
    write_reg(CFG_GATE_DISTANCE, 16'($urandom));
    write_reg(CFG_TICK_RATE, 16'($urandom_range(1, 65535)));
    @(negedge clk);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    random_scans(120);
    hold_req = 1'b1;
    drain();

    in_idle_pct  = 22;
    out_idle_pct = 22;
    write_reg(CFG_LEVEL_THRESHOLD, 16'd6);
    write_reg(CFG_GATE_DISTANCE, 16'($urandom_range(1, 4000)));
    write_reg(CFG_TICK_RATE, 16'($urandom_range(1, 4000)));
    @(negedge clk);
    random_scans(250);
    drain();

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
